>>> sv/ipte_pkg.sv
// Shared types and constants for the IPv4/TCP payload extractor.
package ipte_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 16;
  localparam int NIB_W  = 4;
  localparam int ADDR_W = 32;
  localparam int END_W  = 7;

  localparam logic [NIB_W-1:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [END_W-1:0] TCP_OFF_BYTE  = 7'd12;

  localparam logic [POS_W-1:0] POS_IHL      = 16'd0;
  localparam logic [POS_W-1:0] POS_TLEN_HI  = 16'd2;
  localparam logic [POS_W-1:0] POS_TLEN_LO  = 16'd3;
  localparam logic [POS_W-1:0] POS_SRC_LO   = 16'd12;
  localparam logic [POS_W-1:0] POS_SRC_HI   = 16'd15;
  localparam logic [POS_W-1:0] POS_DST_LO   = 16'd16;
  localparam logic [POS_W-1:0] POS_DST_HI   = 16'd19;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t payload_byte;
    logic  last_of_packet;
  } result_t;

  function automatic logic [NIB_W-1:0] clamp_words(input logic [NIB_W-1:0] nib);
    return (nib < MIN_HDR_WORDS) ? MIN_HDR_WORDS : nib;
  endfunction

endpackage

>>> sv/ipte_ifs.sv
// Valid/ready channel interfaces for the byte input and the payload output.
interface ipte_byte_if import ipte_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t stream_byte;

  modport source(output valid, output stream_byte, input ready);
  modport sink(input valid, input stream_byte, output ready);
endinterface

interface ipte_payload_if import ipte_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t payload_byte;
  logic  last_of_packet;

  modport source(output valid, output payload_byte, output last_of_packet, input ready);
  modport sink(input valid, input payload_byte, input last_of_packet, output ready);
endinterface

>>> sv/ipte_in_reg.sv
// Input register stage: holds one accepted stream byte until the parser takes it.
module ipte_in_reg import ipte_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ipte_byte_if.sink    in_ch,
  input  logic         consume,
  output logic         vld,
  output byte_t        data
);

  logic  vld_r;
  byte_t data_r;
  logic  take;

  assign in_ch.ready = !vld_r || consume;
  assign take        = in_ch.valid && in_ch.ready;
  assign vld         = vld_r;
  assign data        = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (consume) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_ch.stream_byte;
    end
  end

endmodule

>>> sv/ipte_parser.sv
// Header parser: packet layout state, server/client capture and payload select.
module ipte_parser import ipte_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  byte_t   data,
  input  logic    step,
  output logic    emit,
  output result_t result
);

  logic [POS_W-1:0]  pos_r;
  logic [NIB_W-1:0]  ihl_r, ihl_nxt;
  logic [NIB_W-1:0]  thl_r, thl_nxt;
  logic [POS_W-1:0]  tlen_r, tlen_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;
  logic [ADDR_W-1:0] server_r, server_nxt;
  logic [ADDR_W-1:0] client_r, client_nxt;
  logic              seen_r, seen_nxt;

  logic [END_W-1:0]  ip_end, tcp_off_pos, hdr_end;
  logic [POS_W-1:0]  pkt_end;
  logic [POS_W:0]    pos_inc;
  logic              at_end;

  always_comb begin
    ihl_nxt    = ihl_r;
    tlen_nxt   = tlen_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    server_nxt = server_r;
    client_nxt = client_r;
    seen_nxt   = seen_r;

    if (pos_r == POS_IHL) begin
      ihl_nxt = clamp_words(data[NIB_W-1:0]);
    end else if (pos_r == POS_TLEN_HI) begin
      tlen_nxt = {data, tlen_r[BYTE_W-1:0]};
    end else if (pos_r == POS_TLEN_LO) begin
      tlen_nxt = {tlen_r[POS_W-1:BYTE_W], data};
    end else if (pos_r >= POS_SRC_LO && pos_r <= POS_SRC_HI) begin
      src_nxt = {src_r[ADDR_W-BYTE_W-1:0], data};
    end else if (pos_r >= POS_DST_LO && pos_r <= POS_DST_HI) begin
      dst_nxt = {dst_r[ADDR_W-BYTE_W-1:0], data};
      if (pos_r == POS_DST_HI && !seen_r) begin
        server_nxt = dst_nxt;
        client_nxt = src_r;
        seen_nxt   = 1'b1;
      end
    end

    ip_end      = {1'b0, ihl_nxt, 2'b00};
    tcp_off_pos = ip_end + TCP_OFF_BYTE;
    thl_nxt     = (pos_r == {{(POS_W-END_W){1'b0}}, tcp_off_pos})
                  ? clamp_words(data[BYTE_W-1:NIB_W]) : thl_r;
    hdr_end     = ip_end + {1'b0, thl_nxt, 2'b00};
    pkt_end     = (tlen_nxt > {{(POS_W-END_W){1'b0}}, hdr_end})
                  ? tlen_nxt : {{(POS_W-END_W){1'b0}}, hdr_end};
    pos_inc     = {1'b0, pos_r} + {{POS_W{1'b0}}, 1'b1};
    at_end      = pos_inc >= {1'b0, pkt_end};

    emit = (pos_r >= {{(POS_W-END_W){1'b0}}, hdr_end}) &&
           (pos_r >  {{(POS_W-END_W){1'b0}}, tcp_off_pos}) &&
           seen_nxt && (src_nxt == server_nxt) && (dst_nxt == client_nxt);

    result.payload_byte   = data;
    result.last_of_packet = at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ihl_r    <= MIN_HDR_WORDS;
      thl_r    <= MIN_HDR_WORDS;
      tlen_r   <= '0;
      src_r    <= '0;
      dst_r    <= '0;
      server_r <= '0;
      client_r <= '0;
      seen_r   <= 1'b0;
    end else if (step) begin
      tlen_r   <= tlen_nxt;
      src_r    <= src_nxt;
      dst_r    <= dst_nxt;
      server_r <= server_nxt;
      client_r <= client_nxt;
      seen_r   <= seen_nxt;
      if (at_end) begin
        pos_r <= '0;
        ihl_r <= MIN_HDR_WORDS;
        thl_r <= MIN_HDR_WORDS;
      end else begin
        pos_r <= pos_inc[POS_W-1:0];
        ihl_r <= ihl_nxt;
        thl_r <= thl_nxt;
      end
    end
  end

endmodule

>>> sv/ipte_out_reg.sv
// Result register: holds one payload byte until the receiver takes it.
module ipte_out_reg import ipte_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  result_t       data,
  output logic          free,
  ipte_payload_if.source out_ch
);

  logic    vld_r;
  result_t data_r;

  assign free                  = !vld_r || out_ch.ready;
  assign out_ch.valid          = vld_r;
  assign out_ch.payload_byte   = data_r.payload_byte;
  assign out_ch.last_of_packet = data_r.last_of_packet;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

endmodule

>>> sv/ipv4_tcp_payload_extractor.sv
// Top level of the IPv4/TCP payload extractor.
//
// in_ch carries the raw byte stream of back-to-back IPv4/TCP packets, one byte
// per transfer. out_ch carries the TCP payload bytes of packets that run from
// the server to the client, with last_of_packet set on the final payload byte
// of each packet. The first packet seen fixes the server (its destination) and
// the client (its source). Other bytes are consumed without a result.
// Throughput: one byte per cycle while no held result stalls a payload byte. A byte
// is captured in the input register, is parsed, and its result is registered in the
// result register, from which a payload byte is presented as valid on out_ch.
// Reset clears both registers and the parser: byte position zero, header
// lengths five words, no server or client known.
// When the receiver stalls, a held result blocks only the next byte that
// would produce a result; header and non-payload bytes keep flowing, and
// in_ch.ready drops once the input register is also held.
module ipv4_tcp_payload_extractor import ipte_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  ipte_byte_if.sink      in_ch,
  ipte_payload_if.source out_ch
);

  logic    s1_vld;
  byte_t   s1_data;
  logic    emit;
  result_t res;
  logic    out_free;
  logic    consume;

  assign consume = s1_vld && (!emit || out_free);

  ipte_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .consume (consume),
    .vld     (s1_vld),
    .data    (s1_data)
  );

  ipte_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .data   (s1_data),
    .step   (consume),
    .emit   (emit),
    .result (res)
  );

  ipte_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (consume && emit),
    .data   (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

>>> test/tb_ipv4_tcp_payload_extractor.sv
// Testbench for the IPv4/TCP payload extractor: packet stimulus, prediction and checking.
`timescale 1ns / 1ps

module tb_ipv4_tcp_payload_extractor;
  import ipte_pkg::*;

  class payload_scoreboard;
    result_t     pending_payloads[$];
    int unsigned failures;
    logic [15:0] pos;
    logic [3:0]  ip_words;
    logic [3:0]  tcp_words;
    logic [15:0] pkt_len;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] server;
    logic [31:0] client;
    bit          have_peers;

    function new();
      failures   = 0;
      pos        = '0;
      ip_words   = MIN_HDR_WORDS;
      tcp_words  = MIN_HDR_WORDS;
      pkt_len    = '0;
      src_addr   = '0;
      dst_addr   = '0;
      server     = '0;
      client     = '0;
      have_peers = 1'b0;
    endfunction

    static function logic [3:0] at_least_five(input logic [3:0] nib);
      if (nib < MIN_HDR_WORDS) begin
        return MIN_HDR_WORDS;
      end
      return nib;
    endfunction

    // Advance the parser by one byte and queue the payload byte it yields, if any.
    function void note_byte(input byte_t b);
      int unsigned p;
      int unsigned ip_end;
      int unsigned hdr_end;
      int unsigned pkt_end;
      result_t     r;
      p = pos;
      if (p == POS_IHL) begin
        ip_words = at_least_five(b[3:0]);
      end else if (p == POS_TLEN_HI) begin
        pkt_len[15:8] = b;
      end else if (p == POS_TLEN_LO) begin
        pkt_len[7:0] = b;
      end else if (p >= POS_SRC_LO && p <= POS_SRC_HI) begin
        src_addr = {src_addr[23:0], b};
      end else if (p >= POS_DST_LO && p <= POS_DST_HI) begin
        dst_addr = {dst_addr[23:0], b};
        if (p == POS_DST_HI && !have_peers) begin
          server     = dst_addr;
          client     = src_addr;
          have_peers = 1'b1;
        end
      end
      ip_end = 4 * ip_words;
      if (p == ip_end + TCP_OFF_BYTE) begin
        tcp_words = at_least_five(b[7:4]);
      end
      hdr_end = ip_end + 4 * tcp_words;
      pkt_end = (pkt_len > hdr_end) ? pkt_len : hdr_end;
      if (p >= hdr_end && p > ip_end + TCP_OFF_BYTE && have_peers &&
          src_addr == server && dst_addr == client) begin
        r.payload_byte   = b;
        r.last_of_packet = (p + 1 >= pkt_end);
        pending_payloads.push_back(r);
      end
      if (p + 1 >= pkt_end) begin
        pos       = '0;
        ip_words  = MIN_HDR_WORDS;
        tcp_words = MIN_HDR_WORDS;
      end else begin
        pos = 16'(p + 1);
      end
    endfunction

    function void check_payload(input result_t got);
      result_t want;
      if (pending_payloads.size() == 0) begin
        $error("unexpected payload transfer: payload_byte %0h", got.payload_byte);
        failures++;
        return;
      end
      want = pending_payloads.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, actual %0h", want.payload_byte, got.payload_byte);
        failures++;
      end
      if (got.last_of_packet !== want.last_of_packet) begin
        $error("last_of_packet: expected %0b, actual %0b",
               want.last_of_packet, got.last_of_packet);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int unsigned bytes_sent;
  logic [31:0] server_ip;
  logic [31:0] client_ip;
  payload_scoreboard sb;

  ipte_byte_if    in_if();
  ipte_payload_if out_if();

  ipv4_tcp_payload_extractor DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_byte(in_if.stream_byte);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.payload_byte   = out_if.payload_byte;
      got.last_of_packet = out_if.last_of_packet;
      sb.check_payload(got);
    end
  end

  task automatic send_byte(input byte_t b);
    while (!calm && $urandom_range(99) < 9) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.stream_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  // Builds one packet; with exact set the total length covers header plus payload_len.
  task automatic send_packet(input logic [3:0] ihl_nib, input logic [3:0] off_nib,
                             input logic [31:0] src, input logic [31:0] dst,
                             input bit exact, input int unsigned payload_len,
                             input logic [15:0] raw_len);
    int unsigned ip_bytes;
    int unsigned hdr_bytes;
    int unsigned span;
    logic [15:0] tot;
    byte_t       b;
    ip_bytes  = 4 * payload_scoreboard::at_least_five(ihl_nib);
    hdr_bytes = ip_bytes + 4 * payload_scoreboard::at_least_five(off_nib);
    tot       = exact ? 16'(hdr_bytes + payload_len) : raw_len;
    span      = (tot > hdr_bytes) ? tot : hdr_bytes;
    for (int unsigned i = 0; i < span; i++) begin
      b = byte_t'($urandom);
      if (i == POS_IHL) begin
        b[3:0] = ihl_nib;
      end else if (i == POS_TLEN_HI) begin
        b = tot[15:8];
      end else if (i == POS_TLEN_LO) begin
        b = tot[7:0];
      end else if (i >= POS_SRC_LO && i <= POS_SRC_HI) begin
        b = byte_t'(src >> (8 * (POS_SRC_HI - i)));
      end else if (i >= POS_DST_LO && i <= POS_DST_HI) begin
        b = byte_t'(dst >> (8 * (POS_DST_HI - i)));
      end else if (i == ip_bytes + TCP_OFF_BYTE) begin
        b[7:4] = off_nib;
      end
      send_byte(b);
    end
  endtask

  task automatic drain_payloads();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_payloads.size() != 0);
  endtask

  function automatic logic [3:0] pick_words();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      return 4'd5;
    end else if (r < 85) begin
      return 4'($urandom_range(15, 6));
    end
    return 4'($urandom_range(4, 0));
  endfunction

  task automatic send_random_packet();
    logic [31:0] src;
    logic [31:0] dst;
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(99);
    len  = ($urandom_range(19) == 0) ? $urandom_range(200, 40) : $urandom_range(24);
    if (kind < 62) begin
      src = server_ip;
      dst = client_ip;
    end else if (kind < 80) begin
      src = client_ip;
      dst = server_ip;
    end else if (kind < 90) begin
      src = $urandom;
      dst = $urandom;
    end else begin
      // near miss on the client address
      src = server_ip;
      dst = client_ip ^ (32'h1 << $urandom_range(31));
    end
    if ($urandom_range(9) == 0) begin
      send_packet(pick_words(), pick_words(), src, dst, 1'b0, 0, 16'($urandom_range(90)));
    end else begin
      send_packet(pick_words(), pick_words(), src, dst, 1'b1, len, '0);
    end
  endtask

  initial begin
    int unsigned random_start;
    int unsigned pkt_count;
    sb                = new();
    calm              = 1'b0;
    bytes_sent        = 0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.stream_byte = '0;
    server_ip         = $urandom;
    do client_ip = $urandom; while (client_ip == server_ip);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first packet fixes the peers
    send_packet(4'd5, 4'd5, client_ip, server_ip, 1'b1, 3, '0);
    send_packet(4'd5, 4'd5, server_ip, client_ip, 1'b1, 2, '0);
    send_packet(4'd0, 4'd4, server_ip, client_ip, 1'b1, 2, '0);
    send_packet(4'd15, 4'd15, server_ip, client_ip, 1'b1, 2, '0);
    send_packet(4'd5, 4'd5, server_ip, client_ip, 1'b0, 0, 16'd0);
    send_packet(4'd6, 4'd5, server_ip, client_ip, 1'b0, 0, 16'd30);
    send_packet(4'd5, 4'd5, server_ip, client_ip, 1'b1, 0, '0);
    send_packet(4'd5, 4'd5, ~server_ip, ~client_ip, 1'b1, 3, '0);
    send_packet(4'd5, 4'd5, client_ip, server_ip, 1'b1, 3, '0);
    send_packet(4'd5, 4'd5, server_ip, client_ip, 1'b1, 1, '0);
    drain_payloads();

    random_start = bytes_sent;
    pkt_count    = 0;
    while (bytes_sent - random_start < 620) begin
      calm = (pkt_count >= 8 && pkt_count < 20);
      send_random_packet();
      if ($urandom_range(99) < 3) begin
        drain_payloads();
      end
      pkt_count++;
    end
    calm = 1'b0;
    drain_payloads();
    repeat (8) @(posedge clk);

    if (sb.failures == 0 && sb.pending_payloads.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> ipv4_tcp_payload_extractor.f
sv/ipte_pkg.sv
sv/ipte_ifs.sv
sv/ipte_in_reg.sv
sv/ipte_parser.sv
sv/ipte_out_reg.sv
sv/ipv4_tcp_payload_extractor.sv
test/tb_ipv4_tcp_payload_extractor.sv
